// ----- design/bpe_pkg.sv -----
// Shared types and constants for the Bezier point evaluator.
// Holds the control-point register map and its reset values.
// No dependencies; used by bezier_point_eval.
`timescale 1ns / 1ps
`default_nettype none

package bpe_pkg;

    // Largest number of control points the register file holds.
    localparam int CTRL_MAX = 4;
    // Two coordinates per control point.
    localparam int NUM_REGS = 2 * CTRL_MAX;
    localparam int REG_IDX_BITS = 3;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_P0_X = 3'd0,
        REG_P0_Y = 3'd1,
        REG_P1_X = 3'd2,
        REG_P1_Y = 3'd3,
        REG_P2_X = 3'd4,
        REG_P2_Y = 3'd5,
        REG_P3_X = 3'd6,
        REG_P3_Y = 3'd7
    } t_reg_idx;

    // Reset values in register order, truncated to the coordinate width on use.
    localparam logic [15:0] RESET_VAL [NUM_REGS] = '{
        16'd250, 16'd50, 16'd750, 16'd50, 16'd1000, 16'd300, 16'd750, 16'd550
    };

endpackage

`default_nettype wire

// ----- design/bpe_level.sv -----
// One de Casteljau level: NUM_IN points reduce to NUM_IN-1 points in x and y.
// Two register stages: multiply t by the neighbor difference, then add the base.
// Depends on nothing outside this file.
`timescale 1ns / 1ps
`default_nettype none

module bpe_level #(
    parameter int NUM_IN     = 4,
    parameter int FRAC_BITS  = 20,
    parameter int COORD_BITS = 10
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    input  wire logic [FRAC_BITS-1:0]                i_t,
    input  wire logic [NUM_IN-1:0][COORD_BITS-1:0]   i_x,
    input  wire logic [NUM_IN-1:0][COORD_BITS-1:0]   i_y,
    output logic                                     o_valid,
    output logic [FRAC_BITS-1:0]                     o_t,
    output logic [NUM_IN-2:0][COORD_BITS-1:0]        o_x,
    output logic [NUM_IN-2:0][COORD_BITS-1:0]        o_y
);

    localparam int NUM_OUT   = NUM_IN - 1;
    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int PROD_BITS = FRAC_BITS + 1 + DIFF_BITS;
    localparam int SUM_BITS  = COORD_BITS + 2;

    // Stage A: products and base values.
    logic                                  r_a_valid;
    logic [FRAC_BITS-1:0]                  r_a_t;
    logic signed [PROD_BITS-1:0]           r_a_prod_x [NUM_OUT];
    logic signed [PROD_BITS-1:0]           r_a_prod_y [NUM_OUT];
    logic [NUM_OUT-1:0][COORD_BITS-1:0]    r_a_base_x;
    logic [NUM_OUT-1:0][COORD_BITS-1:0]    r_a_base_y;

    logic signed [PROD_BITS-1:0]           n_prod_x [NUM_OUT];
    logic signed [PROD_BITS-1:0]           n_prod_y [NUM_OUT];
    logic [NUM_OUT-1:0][COORD_BITS-1:0]    n_sum_x;
    logic [NUM_OUT-1:0][COORD_BITS-1:0]    n_sum_y;

    logic                                  r_b_valid;
    logic [FRAC_BITS-1:0]                  r_b_t;
    logic [NUM_OUT-1:0][COORD_BITS-1:0]    r_b_x;
    logic [NUM_OUT-1:0][COORD_BITS-1:0]    r_b_y;

    // (1 - t) * a + t * b equals a * 1 + t * (b - a), so one signed product
    // per lerp suffices; the arithmetic shift then gives the floor.
    always_comb begin
        for (int k = 0; k < NUM_OUT; k++) begin
            n_prod_x[k] = PROD_BITS'($signed({1'b0, i_t})) *
                          PROD_BITS'($signed({1'b0, i_x[k+1]}) - $signed({1'b0, i_x[k]}));
            n_prod_y[k] = PROD_BITS'($signed({1'b0, i_t})) *
                          PROD_BITS'($signed({1'b0, i_y[k+1]}) - $signed({1'b0, i_y[k]}));
        end
    end

    always_comb begin
        logic signed [SUM_BITS-1:0] sx;
        logic signed [SUM_BITS-1:0] sy;
        for (int k = 0; k < NUM_OUT; k++) begin
            sx = $signed({2'b00, r_a_base_x[k]}) +
                 SUM_BITS'(r_a_prod_x[k] >>> FRAC_BITS);
            sy = $signed({2'b00, r_a_base_y[k]}) +
                 SUM_BITS'(r_a_prod_y[k] >>> FRAC_BITS);
            n_sum_x[k] = sx[COORD_BITS-1:0];
            n_sum_y[k] = sy[COORD_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_t      <= i_t;
        r_a_base_x <= i_x[NUM_OUT-1:0];
        r_a_base_y <= i_y[NUM_OUT-1:0];
        for (int k = 0; k < NUM_OUT; k++) begin
            r_a_prod_x[k] <= n_prod_x[k];
            r_a_prod_y[k] <= n_prod_y[k];
        end
        r_b_t <= r_a_t;
        r_b_x <= n_sum_x;
        r_b_y <= n_sum_y;
    end

    assign o_valid = r_b_valid;
    assign o_t     = r_b_t;
    assign o_x     = r_b_x;
    assign o_y     = r_b_y;

    // Every item that enters leaves through the stage A and stage B registers.
    a_valid_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ##2 o_valid)
        else $error("bpe_level: item lost in level pipeline");

    // A convex combination stays within the range of its two inputs.
    a_x_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ##2 (o_x[0] <= ((($past(i_x[0], 2) > $past(i_x[1], 2))) ?
                                     $past(i_x[0], 2) : $past(i_x[1], 2))))
        else $error("bpe_level: x result above both operands");

endmodule

`default_nettype wire

// ----- design/bezier_point_eval.sv -----
// Top level of the Bezier point evaluator: control-point registers, input
// register and a chain of bpe_level stages. Depends on bpe_pkg and bpe_level.
//
//   channel   ports                                         direction
//   command   start, busy, i_curve_param                    in (busy out)
//   result    o_strobe, o_point_x, o_point_y                out
//   config    i_cfg_we, i_cfg_idx, i_cfg_data               in
//
// The path is one input register, then a multiply stage and an add stage per
// de Casteljau level. A new item is taken in every cycle in which start is high
// and busy is low; busy is high during reset and until the ready register sets
// after it. Reset clears the valid bits and loads the default control points.
// Results carry no back-pressure.
`timescale 1ns / 1ps
`default_nettype none

module bezier_point_eval #(
    parameter int NUM_POINTS = 4,
    parameter int FRAC_BITS  = 20,
    parameter int COORD_BITS = 10
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [FRAC_BITS-1:0]              i_curve_param,
    output logic                                   o_strobe,
    output logic [COORD_BITS-1:0]                  o_point_x,
    output logic [COORD_BITS-1:0]                  o_point_y,
    input  wire logic                              i_cfg_we,
    input  wire logic [bpe_pkg::REG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [COORD_BITS-1:0]             i_cfg_data
);

    localparam int CTRL_MAX   = bpe_pkg::CTRL_MAX;
    localparam int NUM_LEVELS = NUM_POINTS - 1;
    localparam int LATENCY    = 1 + 2 * NUM_LEVELS;

    logic [COORD_BITS-1:0] r_ctrl [bpe_pkg::NUM_REGS];
    logic                  r_ready;
    logic                  r_in_valid;
    logic [FRAC_BITS-1:0]  r_in_t;
    logic                  accept;

    logic                                  s_valid [NUM_LEVELS+1];
    logic [FRAC_BITS-1:0]                  s_t     [NUM_LEVELS+1];
    logic [CTRL_MAX-1:0][COORD_BITS-1:0]   s_x     [NUM_LEVELS+1];
    logic [CTRL_MAX-1:0][COORD_BITS-1:0]   s_y     [NUM_LEVELS+1];

    assign busy   = !r_ready;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < bpe_pkg::NUM_REGS; i++) begin
                r_ctrl[i] <= COORD_BITS'(bpe_pkg::RESET_VAL[i]);
            end
        end else if (i_cfg_we) begin
            case (bpe_pkg::t_reg_idx'(i_cfg_idx))
                bpe_pkg::REG_P0_X: r_ctrl[0] <= i_cfg_data;
                bpe_pkg::REG_P0_Y: r_ctrl[1] <= i_cfg_data;
                bpe_pkg::REG_P1_X: r_ctrl[2] <= i_cfg_data;
                bpe_pkg::REG_P1_Y: r_ctrl[3] <= i_cfg_data;
                bpe_pkg::REG_P2_X: r_ctrl[4] <= i_cfg_data;
                bpe_pkg::REG_P2_Y: r_ctrl[5] <= i_cfg_data;
                bpe_pkg::REG_P3_X: r_ctrl[6] <= i_cfg_data;
                bpe_pkg::REG_P3_Y: r_ctrl[7] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready    <= 1'b0;
            r_in_valid <= 1'b0;
        end else begin
            r_ready    <= 1'b1;
            r_in_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_t <= i_curve_param;
    end

    // Level zero sees the control points straight from the register file.
    always_comb begin
        s_valid[0] = r_in_valid;
        s_t[0]     = r_in_t;
        for (int k = 0; k < CTRL_MAX; k++) begin
            s_x[0][k] = r_ctrl[2*k];
            s_y[0][k] = r_ctrl[2*k+1];
        end
    end

    for (genvar l = 0; l < NUM_LEVELS; l++) begin : g_level
        localparam int NUM_IN = NUM_POINTS - l;

        bpe_level #(
            .NUM_IN     (NUM_IN),
            .FRAC_BITS  (FRAC_BITS),
            .COORD_BITS (COORD_BITS)
        ) u_level (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_valid[l]),
            .i_t     (s_t[l]),
            .i_x     (s_x[l][NUM_IN-1:0]),
            .i_y     (s_y[l][NUM_IN-1:0]),
            .o_valid (s_valid[l+1]),
            .o_t     (s_t[l+1]),
            .o_x     (s_x[l+1][NUM_IN-2:0]),
            .o_y     (s_y[l+1][NUM_IN-2:0])
        );

        assign s_x[l+1][CTRL_MAX-1:NUM_IN-1] = '0;
        assign s_y[l+1][CTRL_MAX-1:NUM_IN-1] = '0;
    end

    assign o_strobe  = s_valid[NUM_LEVELS];
    assign o_point_x = s_x[NUM_LEVELS][0];
    assign o_point_y = s_y[NUM_LEVELS][0];

    // Every accepted transfer produces a result once it has passed the input register and every level.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LATENCY o_strobe)
        else $error("bezier_point_eval: accepted item produced no result");

    // No result appears without an accepted transfer behind it.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(accept, LATENCY))
        else $error("bezier_point_eval: result without matching transfer");

    // Reset empties the pipeline.
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("bezier_point_eval: result right after reset");

endmodule

`default_nettype wire
